@@ rtl/sbad_pkg.sv @@
`default_nettype none

package sbad_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int TAG_W         = 8;
  // 17-bit signed differences multiply into a 34-bit signed area
  localparam int AREA_W        = 2 * (COORD_W + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] box_x_start;
    logic signed [COORD_W-1:0] box_y_start;
    logic signed [COORD_W-1:0] box_x_end;
    logic signed [COORD_W-1:0] box_y_end;
    logic        [SCORE_W-1:0] box_score;
    logic        [TAG_W-1:0]   box_tag;
    logic                      no_box;
    logic                      batch_last;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x_start;
    logic signed [COORD_W-1:0] out_y_start;
    logic signed [COORD_W-1:0] out_x_end;
    logic signed [COORD_W-1:0] out_y_end;
    logic        [SCORE_W-1:0] out_score;
    logic        [TAG_W-1:0]   out_tag;
    logic                      out_empty;
    logic                      out_overflow;
    logic                      out_last;
  } out_item_t;

  // one stored box, as kept in the box RAM
  typedef struct packed {
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic        [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_ISSUE,
    S_DRAIN,
    S_WB,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic wr_in;        // store the incoming box
    logic wr_cur;       // write the held box back to its final slot
    logic rd_en;        // RAM read
    logic rd_pass;      // read belongs to a sort pass
    logic rd_first;     // first read of a pass loads the held box
    logic out_load;     // load the output register
    logic out_empty;
    logic out_overflow;
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_fire;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/sbad_chan_if.sv @@
`default_nettype none

interface sbad_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sort_boxes_by_area_desc_core.sv @@
`default_nettype none

// Collects a batch of up to MAX_BOXES boxes (one item per cycle) into a box RAM, and on the
// item marked last returns them, sorted by descending area when sort_enable is set, else in
// arrival order. Boxes beyond capacity are dropped and every result of that batch carries
// out_overflow; an empty batch returns one result with out_empty set. Input is not taken
// while a batch is sorted or returned. Sorting runs one pass per position i = 0..n-2; a pass
// streams the boxes i..n-1 through the single RAM read port, one per cycle, then drains the
// read pipeline and writes the held box back to slot i. Each result is read from the RAM,
// loaded into the output register and held until out_box.ready takes it.
module sort_boxes_by_area_desc_core #(
  parameter int MAX_BOXES = sbad_pkg::MAX_BOXES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_wr_en,
  input  wire logic    cfg_wr_data,
  sbad_chan_if.sink    in_box,
  sbad_chan_if.source  out_box
);

  localparam int AW = $clog2(MAX_BOXES);

  sbad_pkg::ctrl_cmd_t cmd;
  sbad_pkg::ctrl_sts_t sts;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  sbad_pkg::in_item_t  in_data;
  sbad_pkg::out_item_t out_data;
  logic                in_ready;
  logic                out_valid;

  assign in_data      = in_box.data;
  assign in_box.ready = in_ready;
  assign out_box.valid = out_valid;
  assign out_box.data  = out_data;

  sbad_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_box.valid),
    .in_no_box     (in_data.no_box),
    .in_batch_last (in_data.batch_last),
    .in_ready      (in_ready),
    .sts           (sts),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr)
  );

  sbad_dpath #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .in_data   (in_data),
    .out_ready (out_box.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule

`default_nettype wire

@@ rtl/sbad_ram.sv @@
`default_nettype none

module sbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbad_dpath.sv @@
`default_nettype none

module sbad_dpath #(
  parameter int MAX_BOXES = sbad_pkg::MAX_BOXES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sbad_pkg::ctrl_cmd_t          cmd,
  input  wire logic [$clog2(MAX_BOXES)-1:0] wr_addr,
  input  wire logic [$clog2(MAX_BOXES)-1:0] rd_addr,
  input  wire sbad_pkg::in_item_t           in_data,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output sbad_pkg::out_item_t               out_data,
  output sbad_pkg::ctrl_sts_t               sts
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int EW = $bits(sbad_pkg::entry_t);

  sbad_pkg::entry_t in_entry;
  sbad_pkg::entry_t rd_entry;
  logic [EW-1:0]    ram_rdata;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_waddr;
  logic             ram_we;

  // read pipeline: s1 = RAM output, s2 = box with its area
  logic                                   s1_v_r, s1_v_nxt;
  logic                                   s1_first_r;
  logic [AW-1:0]                          s1_addr_r;
  logic                                   s2_v_r, s2_v_nxt;
  logic                                   s2_first_r;
  logic [AW-1:0]                          s2_addr_r;
  sbad_pkg::entry_t                       s2_entry_r;
  logic signed [sbad_pkg::AREA_W-1:0]     s2_area_r;
  logic signed [sbad_pkg::COORD_W:0]      dx, dy;
  logic signed [sbad_pkg::AREA_W-1:0]     area;

  sbad_pkg::entry_t                       cur_entry_r, cur_entry_nxt;
  logic signed [sbad_pkg::AREA_W-1:0]     cur_area_r, cur_area_nxt;
  logic                                   swap;

  logic                                   out_valid_r, out_valid_nxt;
  sbad_pkg::out_item_t                    out_data_r, out_data_nxt;

  assign in_entry.x_start = in_data.box_x_start;
  assign in_entry.y_start = in_data.box_y_start;
  assign in_entry.x_end   = in_data.box_x_end;
  assign in_entry.y_end   = in_data.box_y_end;
  assign in_entry.score   = in_data.box_score;
  assign in_entry.tag     = in_data.box_tag;

  assign rd_entry = sbad_pkg::entry_t'(ram_rdata);

  assign dx   = $signed({rd_entry.x_end[sbad_pkg::COORD_W-1], rd_entry.x_end})
              - $signed({rd_entry.x_start[sbad_pkg::COORD_W-1], rd_entry.x_start});
  assign dy   = $signed({rd_entry.y_end[sbad_pkg::COORD_W-1], rd_entry.y_end})
              - $signed({rd_entry.y_start[sbad_pkg::COORD_W-1], rd_entry.y_start});
  assign area = dx * dy;

  // a later box with strictly larger area takes the held slot; the held box goes to its place
  assign swap = s2_v_r && !s2_first_r && (cur_area_r < s2_area_r);

  assign ram_we    = cmd.wr_in || cmd.wr_cur || swap;
  assign ram_waddr = swap ? s2_addr_r : wr_addr;
  assign ram_wdata = cmd.wr_in ? EW'(in_entry) : EW'(cur_entry_r);

  sbad_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_v_nxt      = cmd.rd_en && cmd.rd_pass;
    s2_v_nxt      = s1_v_r;
    cur_entry_nxt = cur_entry_r;
    cur_area_nxt  = cur_area_r;
    if (s2_v_r && (s2_first_r || swap)) begin
      cur_entry_nxt = s2_entry_r;
      cur_area_nxt  = s2_area_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (cmd.out_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_x_start  = rd_entry.x_start;
      out_data_nxt.out_y_start  = rd_entry.y_start;
      out_data_nxt.out_x_end    = rd_entry.x_end;
      out_data_nxt.out_y_end    = rd_entry.y_end;
      out_data_nxt.out_score    = rd_entry.score;
      out_data_nxt.out_tag      = rd_entry.tag;
      if (cmd.out_empty) begin
        out_data_nxt.out_x_start = '0;
        out_data_nxt.out_y_start = '0;
        out_data_nxt.out_x_end   = '0;
        out_data_nxt.out_y_end   = '0;
        out_data_nxt.out_score   = '0;
        out_data_nxt.out_tag     = '0;
      end
      out_data_nxt.out_empty    = cmd.out_empty;
      out_data_nxt.out_overflow = cmd.out_overflow;
      out_data_nxt.out_last     = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r  <= cmd.rd_first;
    s1_addr_r   <= rd_addr;
    s2_first_r  <= s1_first_r;
    s2_addr_r   <= s1_addr_r;
    s2_entry_r  <= rd_entry;
    s2_area_r   <= area;
    cur_entry_r <= cur_entry_nxt;
    cur_area_r  <= cur_area_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.pipe_busy = s1_v_r || s2_v_r;
  assign sts.out_fire  = out_valid_r && out_ready;

endmodule

`default_nettype wire

@@ rtl/sbad_ctrl.sv @@
`default_nettype none

module sbad_ctrl #(
  parameter int MAX_BOXES = sbad_pkg::MAX_BOXES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  input  wire logic                         in_valid,
  input  wire logic                         in_no_box,
  input  wire logic                         in_batch_last,
  output logic                              in_ready,
  input  wire sbad_pkg::ctrl_sts_t          sts,
  output sbad_pkg::ctrl_cmd_t               cmd,
  output logic [$clog2(MAX_BOXES)-1:0]      wr_addr,
  output logic [$clog2(MAX_BOXES)-1:0]      rd_addr
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  sbad_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;   // slot being filled by a sort pass
  logic [AW-1:0]    idx_r, idx_nxt;   // read index of a pass, or result index
  logic             sort_en_r;

  logic             in_fire;
  logic             store;
  logic             full;
  logic [CW-1:0]    count_after;
  logic             idx_at_end;
  logic             pos_done;
  logic             res_last;

  assign in_fire     = in_valid && (state_r == sbad_pkg::S_COLLECT);
  assign full        = (count_r == CW'(MAX_BOXES));
  assign store       = in_fire && !in_no_box && !full;
  assign count_after = store ? count_r + CW'(1) : count_r;
  assign idx_at_end  = (CW'(idx_r) == count_r - CW'(1));
  assign pos_done    = !((CW'(pos_r) + CW'(2)) < count_r);
  assign res_last    = (count_r == '0) || idx_at_end;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbad_pkg::S_COLLECT: begin
        if (in_fire && in_batch_last) begin
          if (count_after == '0) begin
            state_nxt = sbad_pkg::S_OUT_LD;
          end else if (sort_en_r && (count_after > CW'(1))) begin
            state_nxt = sbad_pkg::S_ISSUE;
          end else begin
            state_nxt = sbad_pkg::S_OUT_RD;
          end
        end
      end
      sbad_pkg::S_ISSUE: begin
        if (idx_at_end) begin
          state_nxt = sbad_pkg::S_DRAIN;
        end
      end
      sbad_pkg::S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = sbad_pkg::S_WB;
        end
      end
      sbad_pkg::S_WB: begin
        state_nxt = pos_done ? sbad_pkg::S_OUT_RD : sbad_pkg::S_ISSUE;
      end
      sbad_pkg::S_OUT_RD: begin
        state_nxt = sbad_pkg::S_OUT_LD;
      end
      sbad_pkg::S_OUT_LD: begin
        state_nxt = sbad_pkg::S_OUT_WAIT;
      end
      sbad_pkg::S_OUT_WAIT: begin
        if (sts.out_fire) begin
          state_nxt = res_last ? sbad_pkg::S_COLLECT : sbad_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = sbad_pkg::S_COLLECT;
    endcase
  end

  // counters and flags
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    case (state_r)
      sbad_pkg::S_COLLECT: begin
        count_nxt = count_after;
        if (in_fire && !in_no_box && full) begin
          drop_nxt = 1'b1;
        end
        pos_nxt = '0;
        idx_nxt = '0;
      end
      sbad_pkg::S_ISSUE: begin
        if (!idx_at_end) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      sbad_pkg::S_WB: begin
        if (pos_done) begin
          idx_nxt = '0;
        end else begin
          pos_nxt = pos_r + AW'(1);
          idx_nxt = pos_r + AW'(1);
        end
      end
      sbad_pkg::S_OUT_WAIT: begin
        if (sts.out_fire) begin
          if (res_last) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    wr_addr  = count_r[AW-1:0];
    rd_addr  = idx_r;
    unique case (state_r)
      sbad_pkg::S_COLLECT: begin
        in_ready   = 1'b1;
        cmd.wr_in  = store;
      end
      sbad_pkg::S_ISSUE: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_pass  = 1'b1;
        cmd.rd_first = (idx_r == pos_r);
      end
      sbad_pkg::S_WB: begin
        cmd.wr_cur = 1'b1;
        wr_addr    = pos_r;
      end
      sbad_pkg::S_OUT_RD: begin
        cmd.rd_en = 1'b1;
      end
      sbad_pkg::S_OUT_LD: begin
        cmd.out_load     = 1'b1;
        cmd.out_empty    = (count_r == '0);
        cmd.out_overflow = drop_r;
        cmd.out_last     = res_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sbad_pkg::S_COLLECT;
      count_r   <= '0;
      drop_r    <= 1'b0;
      pos_r     <= '0;
      idx_r     <= '0;
      sort_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) begin
        sort_en_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sort_boxes_by_area_desc_core_tb.sv @@
`timescale 1ns / 100ps

module sort_boxes_by_area_desc_core_tb;

  localparam int N_BOXES     = sbad_pkg::MAX_BOXES_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  sbad_chan_if #(.T(sbad_pkg::in_item_t))  in_ch ();
  sbad_chan_if #(.T(sbad_pkg::out_item_t)) out_ch ();

  sort_boxes_by_area_desc_core #(.MAX_BOXES(N_BOXES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_box     (in_ch.sink),
    .out_box    (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: boxes of the open batch, overflow flag, sort mode
  sbad_pkg::entry_t    held[N_BOXES];
  int                  held_cnt = 0;
  bit                  dropped = 1'b0;
  bit                  sort_on = 1'b0;

  sbad_pkg::in_item_t  pending_boxes[$];
  sbad_pkg::out_item_t expected_boxes[$];

  int        send_idle = 0;
  int        recv_idle = 0;
  int        n_errors = 0;
  int        stall_cycles;
  int        stim_items = 0;

  function automatic longint box_area(sbad_pkg::entry_t e);
    return (longint'($signed(e.x_end)) - longint'($signed(e.x_start))) *
           (longint'($signed(e.y_end)) - longint'($signed(e.y_start)));
  endfunction

  // exchange pass: position i swaps with any later box of strictly larger area
  task automatic rank_by_area();
    sbad_pkg::entry_t tmp;
    longint a_i;
    for (int i = 0; i + 1 < held_cnt; i++) begin
      a_i = box_area(held[i]);
      for (int k = i + 1; k < held_cnt; k++) begin
        if (a_i < box_area(held[k])) begin
          tmp     = held[i];
          held[i] = held[k];
          held[k] = tmp;
          a_i     = box_area(held[i]);
        end
      end
    end
  endtask

  task automatic collect_box(sbad_pkg::in_item_t it);
    sbad_pkg::out_item_t r;
    sbad_pkg::entry_t    e;
    if (!it.no_box) begin
      if (held_cnt < N_BOXES) begin
        e.x_start = it.box_x_start;
        e.y_start = it.box_y_start;
        e.x_end   = it.box_x_end;
        e.y_end   = it.box_y_end;
        e.score   = it.box_score;
        e.tag     = it.box_tag;
        held[held_cnt] = e;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!it.batch_last) return;
    if (held_cnt == 0) begin
      r = '0;
      r.out_empty    = 1'b1;
      r.out_overflow = dropped;
      r.out_last     = 1'b1;
      expected_boxes.push_back(r);
    end else begin
      if (sort_on) rank_by_area();
      for (int i = 0; i < held_cnt; i++) begin
        r.out_x_start  = held[i].x_start;
        r.out_y_start  = held[i].y_start;
        r.out_x_end    = held[i].x_end;
        r.out_y_end    = held[i].y_end;
        r.out_score    = held[i].score;
        r.out_tag      = held[i].tag;
        r.out_empty    = 1'b0;
        r.out_overflow = dropped;
        r.out_last     = (i == held_cnt - 1);
        expected_boxes.push_back(r);
      end
    end
    held_cnt = 0;
    dropped  = 1'b0;
  endtask

  function automatic string box_str(sbad_pkg::out_item_t b);
    return $sformatf("xs=%0d ys=%0d xe=%0d ye=%0d sc=%h tag=%h empty=%b ovf=%b last=%b",
                     b.out_x_start, b.out_y_start, b.out_x_end, b.out_y_end,
                     b.out_score, b.out_tag, b.out_empty, b.out_overflow, b.out_last);
  endfunction

  task automatic check_box(sbad_pkg::out_item_t got);
    sbad_pkg::out_item_t want;
    bit                  bad;
    if (expected_boxes.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected result item: %s", box_str(got));
      return;
    end
    want = expected_boxes.pop_front();
    bad = (got.out_x_start  !== want.out_x_start)  || (got.out_y_start !== want.out_y_start) ||
          (got.out_x_end    !== want.out_x_end)    || (got.out_y_end   !== want.out_y_end)   ||
          (got.out_score    !== want.out_score)    || (got.out_tag     !== want.out_tag)     ||
          (got.out_empty    !== want.out_empty)    ||
          (got.out_overflow !== want.out_overflow) || (got.out_last    !== want.out_last);
    if (bad) begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("result mismatch, expected: %s", box_str(want));
        $display("                   actual: %s", box_str(got));
      end
    end
  endtask

  function automatic sbad_pkg::in_item_t box_of(int xs, int ys, int xe, int ye, bit nob,
                                                bit last);
    sbad_pkg::in_item_t it;
    it.box_x_start = 16'(xs);
    it.box_y_start = 16'(ys);
    it.box_x_end   = 16'(xe);
    it.box_y_end   = 16'(ye);
    it.box_score   = 16'($urandom);
    it.box_tag     = 8'($urandom);
    it.no_box      = nob;
    it.batch_last  = last;
    return it;
  endfunction

  function automatic sbad_pkg::in_item_t make_box(bit nob, bit last);
    sbad_pkg::in_item_t it;
    int unsigned        kind;
    logic signed [15:0] w, h;
    logic [15:0]        edges[4];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    it = box_of($urandom, $urandom, $urandom, $urandom, nob, last);
    kind = $urandom_range(9);
    if (kind == 6 || kind == 7) begin
      // tiny boxes: areas collide often, so equal-area ordering gets exercised
      w = 16'($urandom_range(3));
      h = 16'($urandom_range(3));
      if ($urandom_range(1)) w = -w;
      if ($urandom_range(1)) h = -h;
      it.box_x_end = it.box_x_start + w;
      it.box_y_end = it.box_y_start + h;
    end else if (kind == 8) begin
      it.box_x_start = edges[$urandom_range(3)];
      it.box_y_start = edges[$urandom_range(3)];
      it.box_x_end   = edges[$urandom_range(3)];
      it.box_y_end   = edges[$urandom_range(3)];
    end
    return it;
  endfunction

  task automatic add_batch(int nbox, bit end_nobox);
    for (int i = 0; i < nbox; i++) begin
      if ($urandom_range(19) == 0) pending_boxes.push_back(make_box(1'b1, 1'b0));
      pending_boxes.push_back(make_box(1'b0, !end_nobox && i == nbox - 1));
      stim_items++;
    end
    if (end_nobox || nbox == 0) begin
      pending_boxes.push_back(make_box(1'b1, 1'b1));
      stim_items++;
    end
  endtask

  task automatic random_batches(int quota);
    int goal;
    int sel;
    goal = stim_items + quota;
    while (stim_items < goal) begin
      sel = $urandom_range(99);
      if (sel < 8)
        add_batch(0, 1'b1);
      else if (sel < 28)
        add_batch($urandom_range(30, 9), $urandom_range(1));
      else
        add_batch($urandom_range(8, 1), $urandom_range(3) == 0);
    end
  endtask

  task automatic write_sort(bit v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sort_on     = v;
    @(negedge clk);
  endtask

  // settled view at the falling edge: nothing queued, on the bus or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_boxes.size() != 0 || in_ch.valid || expected_boxes.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // input driver; expectations are formed at the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) collect_box(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_boxes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_box(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_sort(1'b1);
    send_idle = 30;
    recv_idle = 88;

    // corner boxes: full-range areas both signs, ties, zero area, mid-batch filler
    pending_boxes.push_back(box_of(-32768, -32768, 32767, 32767, 1'b0, 1'b0));
    pending_boxes[$].box_score = 16'hffff;
    pending_boxes[$].box_tag   = 8'hff;
    pending_boxes.push_back(box_of(32767, 32767, -32768, -32768, 1'b0, 1'b0));
    pending_boxes[$].box_score = 16'h0000;
    pending_boxes[$].box_tag   = 8'h00;
    pending_boxes.push_back(box_of(-32768, 0, 32767, 0, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(32767, -32768, -32768, 32767, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(1, 2, 3, 4, 1'b1, 1'b0));
    pending_boxes.push_back(box_of(0, 0, 16'h4000, 16'h4000, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(16'h4000, 16'h4000, 0, 0, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(100, 200, 110, 190, 1'b0, 1'b1));
    // empty batch, then a single box
    pending_boxes.push_back(box_of(0, 0, 0, 0, 1'b1, 1'b1));
    pending_boxes.push_back(box_of(-5, -5, 5, 5, 1'b0, 1'b1));
    // three equal areas in different shapes, closed by an item with no box
    pending_boxes.push_back(box_of(0, 0, 3, 4, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(10, 10, 14, 13, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(-8, -8, -6, -2, 1'b0, 1'b0));
    pending_boxes.push_back(box_of(7, 7, 9, 9, 1'b1, 1'b1));
    wait_idle();

    add_batch($urandom_range(70, 65), $urandom_range(1));
    random_batches(50);
    wait_idle();

    write_sort(1'b0);
    send_idle = 88;
    recv_idle = 30;
    add_batch(N_BOXES, $urandom_range(1));
    random_batches(50);
    wait_idle();

    write_sort(1'b1);
    send_idle = 0;
    recv_idle = 0;
    add_batch($urandom_range(70, 65), $urandom_range(1));
    random_batches(50);
    wait_idle();

    repeat (50) @(negedge clk);
    if (n_errors == 0 && expected_boxes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
